// ----- design/validated_sample_averager_defines.svh -----
// Assertion macros shared by the averager top level.
// No dependencies; the including module must provide clk and rst.
`ifndef VALIDATED_SAMPLE_AVERAGER_DEFINES_SVH
`define VALIDATED_SAMPLE_AVERAGER_DEFINES_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define VSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define VSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vsa_pkg.sv -----
// Shared types, constants and microcode program of the sample averager.
// No dependencies.
package vsa_pkg;

  localparam int RING_DEPTH = 8;

  localparam int IN_W   = 12;
  localparam int TEMP_W = 11;
  localparam int HUM_W  = 10;

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int TSUM_W = TEMP_W + $clog2(RING_DEPTH);
  localparam int HSUM_W = HUM_W + $clog2(RING_DEPTH);
  localparam int DIV_W  = TSUM_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(RING_DEPTH - 1);
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIV_W);

  // Acceptance window, tenths of a unit
  localparam logic signed [IN_W-1:0] TEMP_LOW  = -12'sd400;
  localparam logic signed [IN_W-1:0] TEMP_HIGH = 12'sd800;
  localparam logic signed [IN_W-1:0] HUM_LOW   = 12'sd0;
  localparam logic signed [IN_W-1:0] HUM_HIGH  = 12'sd1000;

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_WRITE,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_EMIT
  } vsa_op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_SAMPLE,
    COND_REJECT,
    COND_WALK_MORE,
    COND_DIV_MORE,
    COND_OUT_FULL
  } vsa_cond_t;

  typedef struct packed {
    vsa_op_t          op;
    vsa_cond_t        cond;
    logic [PC_W-1:0]  target;
    logic             take;
  } vsa_ucode_t;

  typedef struct packed {
    logic reject;
    logic walk_more;
    logic div_more;
  } vsa_flags_t;

  // Program step addresses
  localparam logic [PC_W-1:0] ST_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] ST_CHECK = 4'd1;
  localparam logic [PC_W-1:0] ST_WRITE = 4'd2;
  localparam logic [PC_W-1:0] ST_WALK  = 4'd3;
  localparam logic [PC_W-1:0] ST_DINIT = 4'd4;
  localparam logic [PC_W-1:0] ST_DSTEP = 4'd5;
  localparam logic [PC_W-1:0] ST_DDONE = 4'd6;
  localparam logic [PC_W-1:0] ST_EMIT  = 4'd7;
  localparam logic [PC_W-1:0] ST_LOOP  = 4'd8;

  // Control store: a jump is taken when its condition holds, else fall through
  function automatic vsa_ucode_t vsa_ucode(input logic [PC_W-1:0] pc);
    vsa_ucode_t w;
    case (pc)
      ST_WAIT:  w = '{op: OP_LOAD,     cond: COND_NO_SAMPLE, target: ST_WAIT,  take: 1'b1};
      ST_CHECK: w = '{op: OP_CHECK,    cond: COND_REJECT,    target: ST_EMIT,  take: 1'b0};
      ST_WRITE: w = '{op: OP_WRITE,    cond: COND_NEVER,     target: ST_WAIT,  take: 1'b0};
      ST_WALK:  w = '{op: OP_ACCUM,    cond: COND_WALK_MORE, target: ST_WALK,  take: 1'b0};
      ST_DINIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: ST_WAIT,  take: 1'b0};
      ST_DSTEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,  target: ST_DSTEP, take: 1'b0};
      ST_DDONE: w = '{op: OP_DIV_DONE, cond: COND_NEVER,     target: ST_WAIT,  take: 1'b0};
      ST_EMIT:  w = '{op: OP_EMIT,     cond: COND_OUT_FULL,  target: ST_EMIT,  take: 1'b0};
      default:  w = '{op: OP_NONE,     cond: COND_ALWAYS,    target: ST_WAIT,  take: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- design/vsa_seq.sv -----
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on vsa_pkg.
module vsa_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  input  logic                     out_full,
  input  vsa_pkg::vsa_flags_t      flags,
  output logic [vsa_pkg::PC_W-1:0] pc,
  output vsa_pkg::vsa_ucode_t      cw
);

  logic [vsa_pkg::PC_W-1:0] pc_next;
  logic                     jump;

  always_comb begin
    cw = vsa_pkg::vsa_ucode(pc);
    case (cw.cond)
      vsa_pkg::COND_NEVER:     jump = 1'b0;
      vsa_pkg::COND_ALWAYS:    jump = 1'b1;
      vsa_pkg::COND_NO_SAMPLE: jump = !sample_valid;
      vsa_pkg::COND_REJECT:    jump = flags.reject;
      vsa_pkg::COND_WALK_MORE: jump = flags.walk_more;
      vsa_pkg::COND_DIV_MORE:  jump = flags.div_more;
      vsa_pkg::COND_OUT_FULL:  jump = out_full;
      default:                 jump = 1'b1;
    endcase
    pc_next = jump ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= vsa_pkg::ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- design/vsa_datapath.sv -----
// Datapath: sample latch, range check, two sample rings, sum walk and
// serial restoring divider producing the two means. Depends on vsa_pkg.
module vsa_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  vsa_pkg::vsa_op_t                   op,
  input  logic                               enable,
  input  logic signed [vsa_pkg::IN_W-1:0]    temperature_in,
  input  logic signed [vsa_pkg::IN_W-1:0]    humidity_in,
  input  logic                               read_failed,
  output vsa_pkg::vsa_flags_t                flags,
  output logic                               stored,
  output logic                               last_valid,
  output logic signed [vsa_pkg::TEMP_W-1:0]  temperature_mean,
  output logic [vsa_pkg::HUM_W-1:0]          humidity_mean
);

  // latched sample
  logic signed [vsa_pkg::IN_W-1:0] t_smp;
  logic signed [vsa_pkg::IN_W-1:0] h_smp;
  logic                            fail_smp;

  logic signed [vsa_pkg::TEMP_W-1:0] t_ring [vsa_pkg::RING_DEPTH];
  logic [vsa_pkg::HUM_W-1:0]         h_ring [vsa_pkg::RING_DEPTH];
  logic [vsa_pkg::IDX_W-1:0]         slot;
  logic [vsa_pkg::IDX_W-1:0]         walk;

  logic signed [vsa_pkg::TSUM_W-1:0] t_sum;
  logic [vsa_pkg::HSUM_W-1:0]        h_sum;
  logic [vsa_pkg::CNT_W-1:0]         t_cnt;
  logic [vsa_pkg::CNT_W-1:0]         h_cnt;

  logic                              t_neg;
  logic [vsa_pkg::DIV_W-1:0]         t_quo;
  logic [vsa_pkg::DIV_W-1:0]         h_quo;
  logic [vsa_pkg::CNT_W-1:0]         t_rem;
  logic [vsa_pkg::CNT_W-1:0]         h_rem;
  logic [vsa_pkg::DCNT_W-1:0]        div_cnt;

  logic                              in_range;
  logic signed [vsa_pkg::TEMP_W-1:0] t_entry;
  logic [vsa_pkg::HUM_W-1:0]         h_entry;
  logic [vsa_pkg::CNT_W:0]           t_rsh;
  logic [vsa_pkg::CNT_W:0]           h_rsh;
  logic                              t_bit;
  logic                              h_bit;
  logic [vsa_pkg::TEMP_W-1:0]        t_mag;

  always_comb begin
    in_range = !fail_smp
               && (t_smp >= vsa_pkg::TEMP_LOW) && (t_smp <= vsa_pkg::TEMP_HIGH)
               && (h_smp >= vsa_pkg::HUM_LOW) && (h_smp <= vsa_pkg::HUM_HIGH);
    flags.reject    = !(enable && in_range);
    flags.walk_more = (walk != vsa_pkg::LAST_SLOT);
    flags.div_more  = (div_cnt != vsa_pkg::DCNT_W'(1));

    t_entry = t_ring[walk];
    h_entry = h_ring[walk];

    // one restoring division step per ring
    t_rsh = {t_rem, t_quo[vsa_pkg::DIV_W-1]};
    h_rsh = {h_rem, h_quo[vsa_pkg::DIV_W-1]};
    t_bit = (t_rsh >= {1'b0, t_cnt});
    h_bit = (h_rsh >= {1'b0, h_cnt});

    t_mag = t_quo[vsa_pkg::TEMP_W-1:0];
  end

  // ring storage and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vsa_pkg::RING_DEPTH; i++) begin
        t_ring[i] <= '0;
        h_ring[i] <= '0;
      end
      slot             <= '0;
      last_valid       <= 1'b0;
      stored           <= 1'b0;
      temperature_mean <= '0;
      humidity_mean    <= '0;
    end else begin
      case (op)
        vsa_pkg::OP_LOAD: begin
          stored <= 1'b0;
        end
        vsa_pkg::OP_CHECK: begin
          if (enable && !in_range) begin
            last_valid <= 1'b0;
          end
        end
        vsa_pkg::OP_WRITE: begin
          t_ring[slot] <= t_smp[vsa_pkg::TEMP_W-1:0];
          h_ring[slot] <= h_smp[vsa_pkg::HUM_W-1:0];
          slot         <= (slot == vsa_pkg::LAST_SLOT) ? '0 : slot + 1'b1;
        end
        vsa_pkg::OP_DIV_DONE: begin
          if (t_cnt == '0) begin
            temperature_mean <= '0;
          end else begin
            temperature_mean <= t_neg ? -$signed(t_mag) : $signed(t_mag);
          end
          humidity_mean <= (h_cnt == '0) ? '0 : h_quo[vsa_pkg::HUM_W-1:0];
          last_valid    <= 1'b1;
          stored        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers: sample latch, sums, divider
  always_ff @(posedge clk) begin
    case (op)
      vsa_pkg::OP_LOAD: begin
        t_smp    <= temperature_in;
        h_smp    <= humidity_in;
        fail_smp <= read_failed;
      end
      vsa_pkg::OP_WRITE: begin
        walk  <= '0;
        t_sum <= '0;
        h_sum <= '0;
        t_cnt <= '0;
        h_cnt <= '0;
      end
      vsa_pkg::OP_ACCUM: begin
        if (t_entry != '0) begin
          t_sum <= t_sum + vsa_pkg::TSUM_W'(t_entry);
          t_cnt <= t_cnt + 1'b1;
        end
        if (h_entry != '0) begin
          h_sum <= h_sum + vsa_pkg::HSUM_W'(h_entry);
          h_cnt <= h_cnt + 1'b1;
        end
        if (walk != vsa_pkg::LAST_SLOT) begin
          walk <= walk + 1'b1;
        end
      end
      vsa_pkg::OP_DIV_INIT: begin
        t_neg   <= t_sum[vsa_pkg::TSUM_W-1];
        t_quo   <= t_sum[vsa_pkg::TSUM_W-1] ? vsa_pkg::DIV_W'(-t_sum)
                                            : vsa_pkg::DIV_W'(t_sum);
        h_quo   <= vsa_pkg::DIV_W'(h_sum);
        t_rem   <= '0;
        h_rem   <= '0;
        div_cnt <= vsa_pkg::DIV_STEPS;
      end
      vsa_pkg::OP_DIV_STEP: begin
        t_rem   <= t_bit ? vsa_pkg::CNT_W'(t_rsh - {1'b0, t_cnt})
                         : t_rsh[vsa_pkg::CNT_W-1:0];
        h_rem   <= h_bit ? vsa_pkg::CNT_W'(h_rsh - {1'b0, h_cnt})
                         : h_rsh[vsa_pkg::CNT_W-1:0];
        t_quo   <= {t_quo[vsa_pkg::DIV_W-2:0], t_bit};
        h_quo   <= {h_quo[vsa_pkg::DIV_W-2:0], h_bit};
        div_cnt <= div_cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/validated_sample_averager.sv -----
// Stored reading: after acceptance the block checks the range, writes the ring slot, walks the ring sums,
// then runs the one-bit-a-cycle divider and registers the means before the result word is loaded;
// the next word is taken once the program has returned to its wait step.
// Rejected reading or disabled block: the check step goes straight to the emit step, then back to wait.
// One reading in flight at a time; a held result stalls the emit step and so the input.
// Synchronous active-high reset clears rings, means, write slot, valid mark and enable.
`include "validated_sample_averager_defines.svh"

module validated_sample_averager (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              sensor_enable,
  // sample channel
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [vsa_pkg::IN_W-1:0]   temperature_in,
  input  logic signed [vsa_pkg::IN_W-1:0]   humidity_in,
  input  logic                              read_failed,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              accepted,
  output logic                              data_valid,
  output logic signed [vsa_pkg::TEMP_W-1:0] temperature_avg,
  output logic [vsa_pkg::HUM_W-1:0]         humidity_avg
);

  logic                              enable;
  logic [vsa_pkg::PC_W-1:0]          pc;
  vsa_pkg::vsa_ucode_t               cw;
  vsa_pkg::vsa_flags_t               flags;
  logic                              out_full;
  logic                              stored;
  logic                              last_valid;
  logic signed [vsa_pkg::TEMP_W-1:0] temperature_mean;
  logic [vsa_pkg::HUM_W-1:0]         humidity_mean;
  logic                              load_out;

  // configuration register; always able to take a word
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= sensor_enable;
    end
  end

  // a held result blocks only the emit step, never the wait step
  assign out_full     = result_valid && result_stall;
  assign sample_stall = !cw.take;
  assign load_out     = (cw.op == vsa_pkg::OP_EMIT) && !out_full;

  vsa_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .out_full     (out_full),
    .flags        (flags),
    .pc           (pc),
    .cw           (cw)
  );

  vsa_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (cw.op),
    .enable           (enable),
    .temperature_in   (temperature_in),
    .humidity_in      (humidity_in),
    .read_failed      (read_failed),
    .flags            (flags),
    .stored           (stored),
    .last_valid       (last_valid),
    .temperature_mean (temperature_mean),
    .humidity_mean    (humidity_mean)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      accepted        <= stored;
      data_valid      <= last_valid && enable;
      temperature_avg <= temperature_mean;
      humidity_avg    <= humidity_mean;
    end
  end

  // a stored reading leaves the valid mark set while the block stays enabled
  `VSA_ASSERT_SAME(a_acc_implies_valid, result_valid && accepted, data_valid, "stored word without valid mark")
  // one word in flight: input closes the cycle after a take
  `VSA_ASSERT_NEXT(a_one_in_flight, sample_valid && !sample_stall, sample_stall, "second word taken back to back")
  // the input opens only at the wait step of the program
  `VSA_ASSERT_SAME(a_take_at_wait, !sample_stall, pc == vsa_pkg::ST_WAIT, "input open outside wait step")

endmodule
